FILE: sv/yla_pkg.sv
// ----------------------------------------------------------------------------
// yla_pkg
// Shared widths, fixed-point coefficients, register codes and types for the
// YIQ luma adjust pipeline.
// ----------------------------------------------------------------------------
package yla_pkg;

    localparam int CFB       = 14;
    localparam int DFB       = 8;
    localparam int PIX_W     = 8;
    localparam int COEF_W    = 16;
    localparam int FWD_ACC_W = 26;
    localparam int YIQ_W     = 18;
    localparam int YADJ_W    = 27;
    localparam int INV_ACC_W = YADJ_W + CFB + 1;
    localparam int RND_SH    = CFB - DFB;
    localparam int OUT_SH    = CFB + DFB;

    localparam int MODE_W    = 3;
    localparam int AMT_W     = 9;
    localparam int THR_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    localparam int CSCALE = 1 << CFB;

    localparam logic signed [COEF_W-1:0] C_YR = COEF_W'((299 * CSCALE + 500) / 1000);
    localparam logic signed [COEF_W-1:0] C_YG = COEF_W'((587 * CSCALE + 500) / 1000);
    localparam logic signed [COEF_W-1:0] C_YB = COEF_W'((114 * CSCALE + 500) / 1000);
    localparam logic signed [COEF_W-1:0] C_IR = COEF_W'((596 * CSCALE + 500) / 1000);
    localparam logic signed [COEF_W-1:0] C_IG = -COEF_W'((274 * CSCALE + 500) / 1000);
    localparam logic signed [COEF_W-1:0] C_IB = -COEF_W'((322 * CSCALE + 500) / 1000);
    localparam logic signed [COEF_W-1:0] C_QR = COEF_W'((211 * CSCALE + 500) / 1000);
    localparam logic signed [COEF_W-1:0] C_QG = -COEF_W'((523 * CSCALE + 500) / 1000);
    localparam logic signed [COEF_W-1:0] C_QB = COEF_W'((312 * CSCALE + 500) / 1000);

    localparam logic signed [COEF_W-1:0] C_RI = COEF_W'((956 * CSCALE + 500) / 1000);
    localparam logic signed [COEF_W-1:0] C_RQ = COEF_W'((621 * CSCALE + 500) / 1000);
    localparam logic signed [COEF_W-1:0] C_GI = -COEF_W'((272 * CSCALE + 500) / 1000);
    localparam logic signed [COEF_W-1:0] C_GQ = -COEF_W'((647 * CSCALE + 500) / 1000);
    localparam logic signed [COEF_W-1:0] C_BI = -COEF_W'((1106 * CSCALE + 500) / 1000);
    localparam logic signed [COEF_W-1:0] C_BQ = COEF_W'((1703 * CSCALE + 500) / 1000);

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_AMOUNT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = CFG_IDX_W'(2);

    localparam logic [MODE_W-1:0] MODE_PASS   = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_OFFSET = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_GAIN   = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_THRESH = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_NEG    = MODE_W'(4);

    localparam logic [THR_W-1:0] THRESH_RST = THR_W'(128);

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [AMT_W-1:0] amount;
        logic [THR_W-1:0]        thresh;
    } t_cfg;

    typedef struct packed {
        logic signed [YIQ_W-1:0] y;
        logic signed [YIQ_W-1:0] i;
        logic signed [YIQ_W-1:0] q;
    } t_yiq;

    function automatic logic signed [FWD_ACC_W-1:0] fwd_mul(
        input logic [PIX_W-1:0]        pix,
        input logic signed [COEF_W-1:0] coef
    );
        return FWD_ACC_W'($signed({1'b0, pix})) * FWD_ACC_W'(coef);
    endfunction

    function automatic logic signed [INV_ACC_W-1:0] inv_mul(
        input logic signed [YIQ_W-1:0]  val,
        input logic signed [COEF_W-1:0] coef
    );
        return INV_ACC_W'(val) * INV_ACC_W'(coef);
    endfunction

endpackage

FILE: sv/yla_fwd.sv
// ----------------------------------------------------------------------------
// yla_fwd
// RGB to YIQ: one stage of constant products, one stage of sums with
// round-half-up down to the luma/chroma fixed-point format.
// ----------------------------------------------------------------------------
module yla_fwd
    import yla_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    output logic             o_valid,
    input  logic             i_ready,
    output t_yiq             o_yiq
);

    localparam logic signed [FWD_ACC_W-1:0] HALF = FWD_ACC_W'(1) <<< (RND_SH - 1);

    logic                        r_v1;
    logic                        r_v2;
    logic signed [FWD_ACC_W-1:0] r_p [9];
    t_yiq                        r_yiq;
    t_yiq                        n_yiq;
    logic                        en1;
    logic                        en2;
    logic signed [FWD_ACC_W-1:0] sum_y;
    logic signed [FWD_ACC_W-1:0] sum_i;
    logic signed [FWD_ACC_W-1:0] sum_q;

    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v2;
    assign o_yiq   = r_yiq;

    always_comb begin
        sum_y   = r_p[0] + r_p[1] + r_p[2] + HALF;
        sum_i   = r_p[3] + r_p[4] + r_p[5] + HALF;
        sum_q   = r_p[6] + r_p[7] + r_p[8] + HALF;
        n_yiq.y = sum_y[RND_SH +: YIQ_W];
        n_yiq.i = sum_i[RND_SH +: YIQ_W];
        n_yiq.q = sum_q[RND_SH +: YIQ_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_p[0] <= fwd_mul(i_red,   C_YR);
            r_p[1] <= fwd_mul(i_green, C_YG);
            r_p[2] <= fwd_mul(i_blue,  C_YB);
            r_p[3] <= fwd_mul(i_red,   C_IR);
            r_p[4] <= fwd_mul(i_green, C_IG);
            r_p[5] <= fwd_mul(i_blue,  C_IB);
            r_p[6] <= fwd_mul(i_red,   C_QR);
            r_p[7] <= fwd_mul(i_green, C_QG);
            r_p[8] <= fwd_mul(i_blue,  C_QB);
        end
        if (en2 && r_v1) begin
            r_yiq <= n_yiq;
        end
    end

endmodule

FILE: sv/yla_luma.sv
// ----------------------------------------------------------------------------
// yla_luma
// Luma adjustment by mode, in parallel with the chroma products of the
// inverse matrix.
// ----------------------------------------------------------------------------
module yla_luma
    import yla_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cfg                        i_cfg,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  t_yiq                        i_yiq,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [YADJ_W-1:0]    o_y,
    output logic signed [INV_ACC_W-1:0] o_prod [6]
);

    localparam logic signed [YADJ_W-1:0] FULL = YADJ_W'(255) <<< DFB;

    logic                        r_v;
    logic signed [YADJ_W-1:0]    r_y;
    logic signed [YADJ_W-1:0]    n_y;
    logic signed [INV_ACC_W-1:0] r_prod [6];
    logic signed [YADJ_W-1:0]    y_ext;
    logic signed [YADJ_W-1:0]    y_neg;
    logic signed [YADJ_W-1:0]    thr_ext;
    logic                        en;

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_y     = r_y;
    assign o_prod  = r_prod;

    always_comb begin
        y_ext   = YADJ_W'(i_yiq.y);
        y_neg   = y_ext - FULL;
        thr_ext = YADJ_W'($signed({1'b0, i_cfg.thresh})) <<< DFB;
        unique case (i_cfg.mode)
            MODE_OFFSET: begin
                n_y = y_ext + (YADJ_W'(i_cfg.amount) <<< DFB);
            end
            MODE_GAIN: begin
                n_y = y_ext * YADJ_W'(i_cfg.amount);
            end
            MODE_THRESH: begin
                n_y = (y_ext > thr_ext) ? FULL : '0;
            end
            MODE_NEG: begin
                n_y = y_neg[YADJ_W-1] ? -y_neg : y_neg;
            end
            default: begin
                n_y = y_ext;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_y       <= n_y;
            r_prod[0] <= inv_mul(i_yiq.i, C_RI);
            r_prod[1] <= inv_mul(i_yiq.q, C_RQ);
            r_prod[2] <= inv_mul(i_yiq.i, C_GI);
            r_prod[3] <= inv_mul(i_yiq.q, C_GQ);
            r_prod[4] <= inv_mul(i_yiq.i, C_BI);
            r_prod[5] <= inv_mul(i_yiq.q, C_BQ);
        end
    end

endmodule

FILE: sv/yla_inv.sv
// ----------------------------------------------------------------------------
// yla_inv
// Inverse sums back to RGB, clamp each channel to a byte, hold the output
// beat.
// ----------------------------------------------------------------------------
module yla_inv
    import yla_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [YADJ_W-1:0]    i_y,
    input  logic signed [INV_ACC_W-1:0] i_prod [6],
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [PIX_W-1:0]            o_red,
    output logic [PIX_W-1:0]            o_green,
    output logic [PIX_W-1:0]            o_blue
);

    localparam logic signed [INV_ACC_W-1:0] LIM = INV_ACC_W'(255) <<< OUT_SH;

    logic                        r_v;
    logic [PIX_W-1:0]            r_ch [3];
    logic [PIX_W-1:0]            n_ch [3];
    logic signed [INV_ACC_W-1:0] yc;
    logic signed [INV_ACC_W-1:0] acc [3];
    logic                        en;

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_red   = r_ch[0];
    assign o_green = r_ch[1];
    assign o_blue  = r_ch[2];

    always_comb begin
        yc = INV_ACC_W'(i_y) <<< CFB;
        for (int k = 0; k < 3; k++) begin
            acc[k] = yc + i_prod[2*k] + i_prod[2*k+1];
            if (acc[k] <= 0) begin
                n_ch[k] = '0;
            end else if (acc[k] > LIM) begin
                n_ch[k] = '1;
            end else begin
                n_ch[k] = acc[k][OUT_SH +: PIX_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_ch <= n_ch;
        end
    end

endmodule

FILE: sv/yiq_luma_adjust.sv
// ----------------------------------------------------------------------------
// yiq_luma_adjust
// Per-pixel RGB to YIQ conversion, luma adjustment by mode, and conversion
// back to clamped RGB, as a four-stage pipeline.
// ----------------------------------------------------------------------------
// channel    direction  handshake                    payload, lowest bit first
// s_axis     in         s_axis_tvalid/s_axis_tready  red_in, green_in, blue_in
// m_axis     out        m_axis_tvalid/m_axis_tready  red_out, green_out, blue_out
// cfg        in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// One pixel per clock while the output is not stalled.
// Stages: colour products, YIQ sums, luma mode and chroma products, sums and
// clamp into the output register.
// Each stage advances when it is empty or the next one advances, so bubbles
// close up under stall and nothing is lost or repeated.
// Synchronous reset clears the valid bits and sets the registers to their
// defaults (pass through, amount 0, threshold 128).
// ----------------------------------------------------------------------------
module yiq_luma_adjust
    import yla_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // red_in, green_in, blue_in
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // red_out, green_out, blue_out
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg                        r_cfg;
    t_yiq                        yiq;
    logic                        fwd_valid;
    logic                        luma_ready;
    logic                        luma_valid;
    logic                        inv_ready;
    logic signed [YADJ_W-1:0]    y_adj;
    logic signed [INV_ACC_W-1:0] prod [6];
    logic [PIX_W-1:0]            red_out;
    logic [PIX_W-1:0]            green_out;
    logic [PIX_W-1:0]            blue_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= MODE_PASS;
            r_cfg.amount <= '0;
            r_cfg.thresh <= THRESH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_cfg.mode   <= i_cfg_data[MODE_W-1:0];
                CFG_AMOUNT: r_cfg.amount <= i_cfg_data[AMT_W-1:0];
                CFG_THRESH: r_cfg.thresh <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    yla_fwd u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_red   (s_axis_tdata[7:0]),
        .i_green (s_axis_tdata[15:8]),
        .i_blue  (s_axis_tdata[23:16]),
        .o_valid (fwd_valid),
        .i_ready (luma_ready),
        .o_yiq   (yiq)
    );

    yla_luma u_luma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (fwd_valid),
        .o_ready (luma_ready),
        .i_yiq   (yiq),
        .o_valid (luma_valid),
        .i_ready (inv_ready),
        .o_y     (y_adj),
        .o_prod  (prod)
    );

    yla_inv u_inv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (luma_valid),
        .o_ready (inv_ready),
        .i_y     (y_adj),
        .i_prod  (prod),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_red   (red_out),
        .o_green (green_out),
        .o_blue  (blue_out)
    );

    assign m_axis_tdata = {blue_out, green_out, red_out};

endmodule

FILE: sv/yla_checker.sv
// ----------------------------------------------------------------------------
// yla_checker
// Port-level checks on the luma adjust pipeline: output hold, fill latency,
// back-pressure behaviour and no output valid straight after reset.
// ----------------------------------------------------------------------------
module yla_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [23:0] m_axis_tdata     // red_out, green_out, blue_out
);

    logic s_beat;

    assign s_beat = s_axis_tvalid && s_axis_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(s_beat, 4) && $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)
        && $past(m_axis_tready, 1) && $past(m_axis_tready, 2) && $past(m_axis_tready, 3)
        |-> m_axis_tvalid)
        else $error("pixel did not arrive after four cycles without stall");

    a_no_beat_unfed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule

bind yiq_luma_adjust yla_checker u_yla_checker (.*);
